@@ rtl/gpf_pkg.sv @@
package gpf_pkg;

  // Widths fixed by the request and result fields
  localparam int unsigned QW        = 21;
  localparam int unsigned LIMIT_DEF = 1048576;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PC_W      = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_SINIT,
    OP_RD_I,
    OP_LOAD_J,
    OP_RD_J,
    OP_MARK,
    OP_NEXT_I,
    OP_IDLE,
    OP_RD_PQ,
    OP_ADV,
    OP_HIT,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_MORE,
    C_SQ_GT,
    C_BIT_A,
    C_J_GT,
    C_NO_REQ,
    C_P_PAST,
    C_PAIR,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // Step labels of the control program
  localparam pc_t PC_CLEAR  = 4'd0;
  localparam pc_t PC_SINIT  = 4'd1;
  localparam pc_t PC_SLOOP  = 4'd2;
  localparam pc_t PC_STEST  = 4'd3;
  localparam pc_t PC_SREAD  = 4'd4;
  localparam pc_t PC_SMARK  = 4'd5;
  localparam pc_t PC_NEXT_I = 4'd6;
  localparam pc_t PC_IDLE   = 4'd7;
  localparam pc_t PC_QREAD  = 4'd8;
  localparam pc_t PC_QTEST  = 4'd9;
  localparam pc_t PC_QADV   = 4'd10;
  localparam pc_t PC_HIT    = 4'd11;
  localparam pc_t PC_EMIT   = 4'd12;
  localparam pc_t PC_RET    = 4'd13;

  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t cw;
    unique case (pc)
      PC_CLEAR:  cw = '{OP_CLEAR,  C_CLR_MORE, PC_CLEAR};
      PC_SINIT:  cw = '{OP_SINIT,  C_NEVER,    PC_CLEAR};
      PC_SLOOP:  cw = '{OP_RD_I,   C_SQ_GT,    PC_IDLE};
      PC_STEST:  cw = '{OP_LOAD_J, C_BIT_A,    PC_NEXT_I};
      PC_SREAD:  cw = '{OP_RD_J,   C_J_GT,     PC_NEXT_I};
      PC_SMARK:  cw = '{OP_MARK,   C_ALWAYS,   PC_SREAD};
      PC_NEXT_I: cw = '{OP_NEXT_I, C_ALWAYS,   PC_SLOOP};
      PC_IDLE:   cw = '{OP_IDLE,   C_NO_REQ,   PC_IDLE};
      PC_QREAD:  cw = '{OP_RD_PQ,  C_P_PAST,   PC_EMIT};
      PC_QTEST:  cw = '{OP_NOP,    C_PAIR,     PC_HIT};
      PC_QADV:   cw = '{OP_ADV,    C_ALWAYS,   PC_QREAD};
      PC_HIT:    cw = '{OP_HIT,    C_NEVER,    PC_CLEAR};
      PC_EMIT:   cw = '{OP_EMIT,   C_OUT_FULL, PC_EMIT};
      PC_RET:    cw = '{OP_NOP,    C_ALWAYS,   PC_IDLE};
      default:   cw = '{OP_NOP,    C_ALWAYS,   PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/goldbach_prime_pair_finder_top.sv @@
// Reset: the composite bitmap is cleared one word per cycle ((LIMIT >> 6) + 1 words),
// then sieved by marking each odd multiple of each odd prime from its square; requests
// stall until done. Each query tries p from 2 up to n / 2 in read, test and advance
// steps, one dual-port bitmap read of p and n - p per candidate; a pair adds a hit step.
// One request at a time; a new one is taken only after the result loads and a return step,
// later while a stalled result holds. rst_ni (async, low) restarts the clear and sieve.
module goldbach_prime_pair_finder_top #(
  parameter int unsigned LIMIT = gpf_pkg::LIMIT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [gpf_pkg::QW-1:0]   query_number_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [gpf_pkg::QW-1:0]   small_prime_o,
  output logic [gpf_pkg::QW-1:0]   large_prime_o
);

  localparam int unsigned QW    = gpf_pkg::QW;
  localparam int unsigned WW    = gpf_pkg::WORD_W;
  // One bit per odd number, 32 odd numbers (64 values) per word
  localparam int unsigned DEPTH = (LIMIT >> 6) + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Value width: room for LIMIT plus one overshoot step of j and i*i
  localparam int unsigned VW    = $clog2(LIMIT + 1) + 1;
  localparam int unsigned CW    = (VW > QW + 1) ? VW : QW + 1;
  localparam logic [CW-1:0] LIM = CW'(LIMIT);

  // Program counter and decoded control word
  gpf_pkg::pc_t  pc_q, pc_d;
  gpf_pkg::ctrl_t cw;
  logic          take;

  // Sieve datapath
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] sq_q, sq_d;
  logic [CW-1:0] j_q, j_d;

  // Query datapath
  logic [QW-1:0] n_q, n_d;
  logic [QW-1:0] p_q, p_d;
  logic [QW-1:0] q_q, q_d;
  logic          hit_q, hit_d;

  // Result register
  logic          out_valid_q, out_valid_d;
  logic          found_q, found_d;
  logic [QW-1:0] small_q, small_d;
  logic [QW-1:0] large_q, large_d;

  // Bitmap ports
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [WW-1:0] wdata, rdata_a, rdata_b;

  logic in_acc, out_acc, out_full, pair;

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] v);
    logic [CW-1:0] w;
    w = v >> 6;
    if (v > LIM) begin
      return '0;
    end
    return w[AW-1:0];
  endfunction

  // Primality from the fetched bitmap word: 2 by rule, other evens never,
  // values outside the map never.
  function automatic logic prime_of(logic [QW-1:0] v, logic [WW-1:0] word);
    logic [CW-1:0] vx;
    vx = CW'(v);
    if (v == QW'(2)) begin
      return 1'b1;
    end
    if (!v[0] || v == QW'(1) || vx > LIM) begin
      return 1'b0;
    end
    return !word[v[5:1]];
  endfunction

  gpf_bitmap #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_bitmap (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign cw         = gpf_pkg::ucode(pc_q);
  assign in_stall_o = (cw.op != gpf_pkg::OP_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_full   = out_valid_q && out_stall_i;
  // Both reads were issued in the previous step for the current p and q
  assign pair       = prime_of(p_q, rdata_a) && prime_of(q_q, rdata_b);

  // Evaluate the jump condition of the current step
  always_comb begin
    case (cw.cond)
      gpf_pkg::C_NEVER:    take = 1'b0;
      gpf_pkg::C_ALWAYS:   take = 1'b1;
      gpf_pkg::C_CLR_MORE: take = (clr_q != AW'(DEPTH - 1));
      gpf_pkg::C_SQ_GT:    take = (sq_q > LIM);
      gpf_pkg::C_BIT_A:    take = rdata_a[i_q[5:1]];
      gpf_pkg::C_J_GT:     take = (j_q > LIM);
      gpf_pkg::C_NO_REQ:   take = !in_valid_i;
      gpf_pkg::C_P_PAST:   take = ({p_q, 1'b0} > {1'b0, n_q});
      gpf_pkg::C_PAIR:     take = pair;
      gpf_pkg::C_OUT_FULL: take = out_full;
      default:             take = 1'b0;
    endcase
  end

  assign pc_d = take ? cw.target : pc_q + gpf_pkg::PC_W'(1);

  // Datapath actions and bitmap port selection
  always_comb begin
    clr_d       = clr_q;
    i_d         = i_q;
    sq_d        = sq_q;
    j_d         = j_q;
    n_d         = n_q;
    p_d         = p_q;
    q_d         = q_q;
    hit_d       = hit_q;
    found_d     = found_q;
    small_d     = small_q;
    large_d     = large_q;
    out_valid_d = out_valid_q && !out_acc;
    we          = 1'b0;
    waddr       = addr_of(j_q);
    wdata       = rdata_a | (WW'(1) << j_q[5:1]);
    raddr_a     = addr_of(CW'(p_q));
    raddr_b     = addr_of(CW'(q_q));

    unique case (cw.op)
      gpf_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
      end
      gpf_pkg::OP_SINIT: begin
        i_d  = CW'(3);
        sq_d = CW'(9);
      end
      gpf_pkg::OP_RD_I: begin
        raddr_a = addr_of(i_q);
      end
      gpf_pkg::OP_LOAD_J: begin
        j_d = sq_q;
      end
      gpf_pkg::OP_RD_J: begin
        raddr_a = addr_of(j_q);
      end
      gpf_pkg::OP_MARK: begin
        // Set the bit of j in the word just fetched, advance to next odd multiple
        we  = 1'b1;
        j_d = j_q + (i_q << 1);
      end
      gpf_pkg::OP_NEXT_I: begin
        // (i + 2)^2 = i^2 + 4i + 4
        i_d  = i_q + CW'(2);
        sq_d = sq_q + (i_q << 2) + CW'(4);
      end
      gpf_pkg::OP_IDLE: begin
        if (in_acc) begin
          n_d   = query_number_i;
          p_d   = QW'(2);
          q_d   = query_number_i - QW'(2);
          hit_d = 1'b0;
        end
      end
      gpf_pkg::OP_RD_PQ: begin
      end
      gpf_pkg::OP_ADV: begin
        p_d = p_q + QW'(1);
        q_d = q_q - QW'(1);
      end
      gpf_pkg::OP_HIT: begin
        hit_d = 1'b1;
      end
      gpf_pkg::OP_EMIT: begin
        // Load the result register once it is free or being drained
        if (!out_full) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          small_d     = hit_q ? p_q : '0;
          large_d     = hit_q ? q_q : '0;
        end
      end
      gpf_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Control state: program counter, clear counter, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= gpf_pkg::PC_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    sq_q    <= sq_d;
    j_q     <= j_d;
    n_q     <= n_d;
    p_q     <= p_d;
    q_q     <= q_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    small_q <= small_d;
    large_q <= large_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign small_prime_o = small_q;
  assign large_prime_o = large_q;

endmodule

@@ rtl/gpf_bitmap.sv @@
module gpf_bitmap #(
  parameter int unsigned DEPTH = 16385,
  parameter int unsigned AW    = 15
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [gpf_pkg::WORD_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_a_i,
  input  logic [AW-1:0]               raddr_b_i,
  output logic [gpf_pkg::WORD_W-1:0]  rdata_a_o,
  output logic [gpf_pkg::WORD_W-1:0]  rdata_b_o
);

  logic [gpf_pkg::WORD_W-1:0] mem [DEPTH];
  logic [gpf_pkg::WORD_W-1:0] rdata_a_q;
  logic [gpf_pkg::WORD_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/gpf_checker.sv @@
module gpf_props (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic                   found_o,
  input logic [gpf_pkg::QW-1:0] small_prime_o,
  input logic [gpf_pkg::QW-1:0] large_prime_o
);

  // One request in flight: stall right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // A miss carries zero primes
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> small_prime_o == '0 && large_prime_o == '0)
    else $error("miss result with nonzero primes");

  // A hit is ordered and never uses a prime below 2
  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> small_prime_o <= large_prime_o &&
                               small_prime_o >= gpf_pkg::QW'(2))
    else $error("hit result out of order");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) &&
                                   $stable(small_prime_o) && $stable(large_prime_o))
    else $error("stalled result changed");

endmodule

bind goldbach_prime_pair_finder_top gpf_props u_gpf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .found_o      (found_o),
  .small_prime_o(small_prime_o),
  .large_prime_o(large_prime_o)
);
